### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define PLVB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, held off during reset
`define PLVB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/plvb_pkg.sv
// ----------------------------------------------------------------------------
// plvb_pkg
// Shared types and codes of the particle line vertex and bounds block.
// ----------------------------------------------------------------------------
package plvb_pkg;

	localparam int COORD_W = 32;
	localparam int LIMIT_W = 16;
	localparam int AGE_W   = 16;
	localparam int SCALE_W = 16;
	localparam int COLOR_W = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int SQ_W    = 64;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_START    = 2'd0;
	localparam opcode_t OP_PARTICLE = 2'd1;
	localparam opcode_t OP_END      = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	localparam cfg_index_t CFG_LINE_SCALE = 3'd0;
	localparam cfg_index_t CFG_ALPHA_MODE = 3'd1;
	localparam cfg_index_t CFG_USER_ALPHA = 3'd2;
	localparam cfg_index_t CFG_HEAD_COLOR = 3'd3;
	localparam cfg_index_t CFG_TAIL_COLOR = 3'd4;

	typedef logic [2:0] alpha_mode_t;
	localparam alpha_mode_t ALPHA_NONE     = 3'd0;
	localparam alpha_mode_t ALPHA_USER     = 3'd1;
	localparam alpha_mode_t ALPHA_FADE_IN  = 3'd2;
	localparam alpha_mode_t ALPHA_FADE_OUT = 3'd3;
	localparam alpha_mode_t ALPHA_IN_OUT   = 3'd4;

	localparam logic KIND_LINE   = 1'b0;
	localparam logic KIND_SPHERE = 1'b1;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

	localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd256;
	localparam logic [7:0]         USER_ALPHA_RESET = 8'hff;
	localparam logic [COLOR_W-1:0] COLOR_RESET      = 32'hffff_ffff;

	// root unit status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

endpackage

### rtl/plvb_channels.sv
// ----------------------------------------------------------------------------
// plvb channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface plvb_item_if;
	logic                                valid;
	logic                                ready;
	plvb_pkg::opcode_t                   opcode;
	logic [plvb_pkg::LIMIT_W-1:0]        particle_limit;
	logic                                alive;
	logic signed [plvb_pkg::COORD_W-1:0] pos_x;
	logic signed [plvb_pkg::COORD_W-1:0] pos_y;
	logic signed [plvb_pkg::COORD_W-1:0] pos_z;
	logic signed [plvb_pkg::COORD_W-1:0] prev_x;
	logic signed [plvb_pkg::COORD_W-1:0] prev_y;
	logic signed [plvb_pkg::COORD_W-1:0] prev_z;
	logic [plvb_pkg::AGE_W-1:0]          age_fraction;

	modport source (
		output valid, opcode, particle_limit, alive, pos_x, pos_y, pos_z,
			prev_x, prev_y, prev_z, age_fraction,
		input  ready
	);
	modport sink (
		input  valid, opcode, particle_limit, alive, pos_x, pos_y, pos_z,
			prev_x, prev_y, prev_z, age_fraction,
		output ready
	);
endinterface

interface plvb_result_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic signed [plvb_pkg::COORD_W-1:0] a_x;
	logic signed [plvb_pkg::COORD_W-1:0] a_y;
	logic signed [plvb_pkg::COORD_W-1:0] a_z;
	logic signed [plvb_pkg::COORD_W-1:0] b_x;
	logic signed [plvb_pkg::COORD_W-1:0] b_y;
	logic signed [plvb_pkg::COORD_W-1:0] b_z;
	logic [plvb_pkg::COLOR_W-1:0]        head_rgba;
	logic [plvb_pkg::COLOR_W-1:0]        tail_rgba;
	logic [plvb_pkg::COORD_W-1:0]        radius;

	modport source (
		output valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, head_rgba, tail_rgba, radius,
		input  ready
	);
	modport sink (
		input  valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, head_rgba, tail_rgba, radius,
		output ready
	);
endinterface

### rtl/plvb_isqrt.sv
// ----------------------------------------------------------------------------
// plvb_isqrt
// Bit-serial integer square root of a 64-bit value, one result bit a cycle,
// root saturated to 32 bits.
// ----------------------------------------------------------------------------
module plvb_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [plvb_pkg::SQ_W-1:0]     radicand,
	output plvb_pkg::sqrt_stat_t          stat,
	output logic [plvb_pkg::COORD_W-1:0]  root
);

	logic [plvb_pkg::SQ_W-1:0] rem_q;
	logic [plvb_pkg::SQ_W-1:0] res_q;
	logic [4:0]                cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [plvb_pkg::SQ_W-1:0] bit_w;
	logic [plvb_pkg::SQ_W-1:0] trial;

	assign bit_w = plvb_pkg::SQ_W'(1) << {cnt_q, 1'b0};
	assign trial = res_q + bit_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_w;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root = (|res_q[plvb_pkg::SQ_W-1:plvb_pkg::COORD_W]) ? '1
		: res_q[plvb_pkg::COORD_W-1:0];

endmodule

### rtl/particle_line_vertex_and_bounds.sv
// ----------------------------------------------------------------------------
// particle_line_vertex_and_bounds
// Line vertices, per-particle colours and a frame bounding sphere for a
// stream of particles.
// ----------------------------------------------------------------------------
// A start-frame item with a nonzero limit sets the particle limit and
// clears the box; each live particle within the limit widens the box and
// gives one line result; the end-frame item of an open frame gives the box
// centre and radius. Start items, ignored particles and ignored ends are
// finished in the idle state. For a line the three tail axes go one after
// another through a single shared multiplier in a three-stage loop, then
// the result register loads. For an end frame the same loop squares the
// three half-extents, then a bit-serial root unit finds the radius bit by
// bit. The result register lets the next item be taken while a result waits.
module particle_line_vertex_and_bounds #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  plvb_pkg::cfg_index_t              cfg_index,
	input  logic [plvb_pkg::CFG_W-1:0]        cfg_data,
	plvb_item_if.sink                         item,
	plvb_result_if.source                     result
);

`include "assert_macros.svh"

	localparam int CW = plvb_pkg::COORD_W;
	localparam logic [32:0] CountMax = (33'd1 << COUNT_WIDTH) - 33'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_PUSH
	} state_t;

	// configuration
	logic signed [plvb_pkg::SCALE_W-1:0] line_scale_q;
	plvb_pkg::alpha_mode_t               alpha_mode_q;
	logic [7:0]                          user_alpha_q;
	logic [plvb_pkg::COLOR_W-1:0]        head_color_q;
	logic [plvb_pkg::COLOR_W-1:0]        tail_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_scale_q <= plvb_pkg::SCALE_RESET;
			alpha_mode_q <= plvb_pkg::ALPHA_NONE;
			user_alpha_q <= plvb_pkg::USER_ALPHA_RESET;
			head_color_q <= plvb_pkg::COLOR_RESET;
			tail_color_q <= plvb_pkg::COLOR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				plvb_pkg::CFG_LINE_SCALE: line_scale_q <= cfg_data[plvb_pkg::SCALE_W-1:0];
				plvb_pkg::CFG_ALPHA_MODE: alpha_mode_q <= cfg_data[2:0];
				plvb_pkg::CFG_USER_ALPHA: user_alpha_q <= cfg_data[7:0];
				plvb_pkg::CFG_HEAD_COLOR: head_color_q <= cfg_data;
				plvb_pkg::CFG_TAIL_COLOR: tail_color_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// state
	state_t                   state_q;
	logic signed [CW-1:0]     box_min_q [3];
	logic signed [CW-1:0]     box_max_q [3];
	logic [COUNT_WIDTH-1:0]   remaining_q;
	logic                     frame_active_q;

	// working registers
	logic                     kind_q;
	logic [2:0]               step_q;
	logic signed [CW-1:0]     opa_q [3];
	logic signed [CW-1:0]     opb_q [3];
	logic [plvb_pkg::AGE_W-1:0] age_q;
	logic signed [32:0]       d_s1;
	logic signed [CW-1:0]     p_s1;
	logic signed [CW-1:0]     p_s2;
	logic signed [67:0]       prod_q;
	logic signed [CW-1:0]     tail_q [3];
	logic [plvb_pkg::SQ_W-1:0] acc_q;
	logic [CW-1:0]            radius_q;

	// result register
	logic                     res_valid_q;
	logic                     res_kind_q;
	logic signed [CW-1:0]     res_a_q [3];
	logic signed [CW-1:0]     res_b_q [3];
	logic [plvb_pkg::COLOR_W-1:0] res_head_q;
	logic [plvb_pkg::COLOR_W-1:0] res_tail_q;
	logic [CW-1:0]            res_radius_q;

	logic item_xfer;
	assign item.ready = (state_q == ST_IDLE);
	assign item_xfer  = item.valid && item.ready;

	// limit clipped to the counter
	logic [32:0]            lim_wide;
	logic [COUNT_WIDTH-1:0] lim_cnt;
	assign lim_wide = 33'(item.particle_limit);
	assign lim_cnt  = (lim_wide > CountMax) ? CountMax[COUNT_WIDTH-1:0]
		: lim_wide[COUNT_WIDTH-1:0];

	logic take_particle;
	assign take_particle = frame_active_q && (remaining_q != '0) && item.alive;

	// box centre per axis, floor of the half sum
	logic signed [32:0]   half_sum [3];
	logic signed [CW-1:0] cen [3];
	logic signed [CW-1:0] pos_in [3];
	logic signed [CW-1:0] prev_in [3];
	assign pos_in[0]  = item.pos_x;
	assign pos_in[1]  = item.pos_y;
	assign pos_in[2]  = item.pos_z;
	assign prev_in[0] = item.prev_x;
	assign prev_in[1] = item.prev_y;
	assign prev_in[2] = item.prev_z;

	for (genvar k = 0; k < 3; k++) begin : g_axis
		assign half_sum[k] = {box_min_q[k][CW-1], box_min_q[k]}
			+ {box_max_q[k][CW-1], box_max_q[k]};
		assign cen[k] = half_sum[k][32:1];
	end

	// stage a: difference, magnitude for the sphere
	logic signed [32:0] diff;
	logic signed [32:0] diff_mag;
	assign diff     = {opb_q[0][CW-1], opb_q[0]} - {opa_q[0][CW-1], opa_q[0]};
	assign diff_mag = (kind_q == plvb_pkg::KIND_SPHERE && diff[32]) ? -diff : diff;

	// stage b: the shared multiplier
	logic signed [33:0] mul_a;
	logic signed [33:0] mul_b;
	assign mul_a = {d_s1[32], d_s1};
	assign mul_b = (kind_q == plvb_pkg::KIND_SPHERE) ? {d_s1[32], d_s1}
		: {{18{line_scale_q[plvb_pkg::SCALE_W-1]}}, line_scale_q};

	// stage c: tail add with saturation
	logic signed [50:0] tsum;
	logic signed [CW-1:0] tail_sat;
	always_comb begin
		tsum = {{19{p_s2[CW-1]}}, p_s2} + {prod_q[57], prod_q[57:8]};
		if (!tsum[50] && (|tsum[49:31])) begin
			tail_sat = plvb_pkg::COORD_MAX;
		end else if (tsum[50] && !(&tsum[49:31])) begin
			tail_sat = plvb_pkg::COORD_MIN;
		end else begin
			tail_sat = tsum[CW-1:0];
		end
	end

	// alpha byte
	logic [16:0] age_w;
	logic [16:0] inv_w;
	logic [16:0] lvl;
	logic [24:0] scaled;
	logic [8:0]  a9;
	logic [7:0]  a8;
	logic        use_alpha;
	always_comb begin
		age_w  = {1'b0, age_q};
		inv_w  = 17'h10000 - age_w;
		lvl    = age_w;
		use_alpha = 1'b1;
		case (alpha_mode_q)
			plvb_pkg::ALPHA_FADE_IN:  lvl = age_w;
			plvb_pkg::ALPHA_FADE_OUT: lvl = inv_w;
			plvb_pkg::ALPHA_IN_OUT:   lvl = ((age_w < inv_w) ? age_w : inv_w) << 1;
			plvb_pkg::ALPHA_USER:     lvl = age_w;
			default:                  use_alpha = 1'b0;
		endcase
		scaled = {lvl, 8'b0} - 25'(lvl) + 25'd32768;
		a9     = scaled[24:16];
		a8     = a9[8] ? 8'hff : a9[7:0];
		if (alpha_mode_q == plvb_pkg::ALPHA_USER) begin
			a8 = user_alpha_q;
		end
	end

	// root unit
	logic                 sq_start;
	plvb_pkg::sqrt_stat_t sq_stat;
	logic [CW-1:0]        sq_root;
	assign sq_start = (state_q == ST_ROOT_GO);

	plvb_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (acc_q),
		.stat     (sq_stat),
		.root     (sq_root)
	);

	logic res_load;
	assign res_load = (state_q == ST_PUSH) && (!res_valid_q || result.ready);

	// control and box state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			step_q         <= '0;
			remaining_q    <= '0;
			frame_active_q <= 1'b0;
			res_valid_q    <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				box_min_q[k] <= plvb_pkg::COORD_MAX;
				box_max_q[k] <= plvb_pkg::COORD_MIN;
			end
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_xfer) begin
						step_q <= '0;
						case (item.opcode)
							plvb_pkg::OP_START: begin
								if (item.particle_limit == '0) begin
									frame_active_q <= 1'b0;
								end else begin
									frame_active_q <= 1'b1;
									remaining_q    <= lim_cnt;
									for (int k = 0; k < 3; k++) begin
										box_min_q[k] <= plvb_pkg::COORD_MAX;
										box_max_q[k] <= plvb_pkg::COORD_MIN;
									end
								end
							end
							plvb_pkg::OP_PARTICLE: begin
								if (take_particle) begin
									remaining_q <= remaining_q - COUNT_WIDTH'(1);
									for (int k = 0; k < 3; k++) begin
										if (pos_in[k] < box_min_q[k]) box_min_q[k] <= pos_in[k];
										if (pos_in[k] > box_max_q[k]) box_max_q[k] <= pos_in[k];
									end
									state_q <= ST_RUN;
								end
							end
							plvb_pkg::OP_END: begin
								if (frame_active_q) begin
									frame_active_q <= 1'b0;
									state_q        <= ST_RUN;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) begin
						state_q <= (kind_q == plvb_pkg::KIND_SPHERE) ? ST_ROOT_GO : ST_PUSH;
					end
				end
				ST_ROOT_GO:   state_q <= ST_ROOT_WAIT;
				ST_ROOT_WAIT: if (sq_stat.done) state_q <= ST_PUSH;
				ST_PUSH:      if (res_load) state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			age_q <= item.age_fraction;
			acc_q <= '0;
			if (item.opcode == plvb_pkg::OP_END) begin
				kind_q <= plvb_pkg::KIND_SPHERE;
				for (int k = 0; k < 3; k++) begin
					opa_q[k] <= cen[k];
					opb_q[k] <= box_min_q[k];
				end
			end else begin
				kind_q <= plvb_pkg::KIND_LINE;
				for (int k = 0; k < 3; k++) begin
					opa_q[k] <= pos_in[k];
					opb_q[k] <= prev_in[k];
				end
			end
		end else if (state_q == ST_RUN) begin
			if (step_q <= 3'd2) begin
				d_s1 <= diff_mag;
				p_s1 <= opa_q[0];
				opa_q[0] <= opa_q[1];
				opa_q[1] <= opa_q[2];
				opa_q[2] <= opa_q[0];
				opb_q[0] <= opb_q[1];
				opb_q[1] <= opb_q[2];
				opb_q[2] <= opb_q[0];
			end
			prod_q <= mul_a * mul_b;
			p_s2   <= p_s1;
			if (step_q >= 3'd2) begin
				acc_q     <= acc_q + prod_q[plvb_pkg::SQ_W-1:0];
				tail_q[2] <= tail_sat;
				tail_q[1] <= tail_q[2];
				tail_q[0] <= tail_q[1];
			end
		end
		if (state_q == ST_ROOT_WAIT && sq_stat.done) begin
			radius_q <= sq_root;
		end
		if (res_load) begin
			res_kind_q <= kind_q;
			for (int k = 0; k < 3; k++) begin
				res_a_q[k] <= opa_q[k];
				res_b_q[k] <= (kind_q == plvb_pkg::KIND_SPHERE) ? '0 : tail_q[k];
			end
			if (kind_q == plvb_pkg::KIND_SPHERE) begin
				res_head_q   <= '0;
				res_tail_q   <= '0;
				res_radius_q <= radius_q;
			end else begin
				res_head_q   <= use_alpha ? {head_color_q[31:8], a8} : head_color_q;
				res_tail_q   <= use_alpha ? {tail_color_q[31:8], a8} : tail_color_q;
				res_radius_q <= '0;
			end
		end
	end

	assign result.valid     = res_valid_q;
	assign result.kind      = res_kind_q;
	assign result.a_x       = res_a_q[0];
	assign result.a_y       = res_a_q[1];
	assign result.a_z       = res_a_q[2];
	assign result.b_x       = res_b_q[0];
	assign result.b_y       = res_b_q[1];
	assign result.b_z       = res_b_q[2];
	assign result.head_rgba = res_head_q;
	assign result.tail_rgba = res_tail_q;
	assign result.radius    = res_radius_q;

	// the count only grows on a start transfer
	`PLVB_ASSERT_NEXT(a_count_no_grow, clk, arst_n, !(item_xfer && item.opcode == plvb_pkg::OP_START), remaining_q <= $past(remaining_q))
	// the root unit is never restarted while working
	`PLVB_ASSERT_IMPLY(a_root_idle_on_start, clk, arst_n, sq_start, !sq_stat.busy)
	// waiting on the root means the unit is running or just finished
	`PLVB_ASSERT_IMPLY(a_root_wait_live, clk, arst_n, state_q == ST_ROOT_WAIT, sq_stat.busy || sq_stat.done)
	// a sphere result closes the frame
	`PLVB_ASSERT_IMPLY(a_sphere_closes, clk, arst_n, res_load && kind_q == plvb_pkg::KIND_SPHERE, !frame_active_q)

endmodule
